[rtl/calu_pkg.sv]
// Package with widths, item types and the group carry types of the cascaded ALU.
package calu_pkg;

  localparam int WIDTH      = 16;
  localparam int SLICE_W    = 4;
  localparam int NUM_SLICES = WIDTH / SLICE_W;

  typedef struct packed {
    logic [WIDTH-1:0] a_operand;
    logic [WIDTH-1:0] b_operand;
    logic [3:0]       func;
    logic             logic_mode;
    logic             carry_in;
  } in_item_t;

  typedef struct packed {
    logic [WIDTH-1:0] result;
    logic             carry_out;
    logic             all_ones;
  } out_item_t;

  typedef struct packed {
    logic prop;
    logic gen;
  } grp_t;

endpackage

[rtl/calu_in_if.sv]
// Input channel interface carrying one operation item.
interface calu_in_if;
  logic                      valid;
  logic                      ready;
  logic [calu_pkg::WIDTH-1:0] a_operand;
  logic [calu_pkg::WIDTH-1:0] b_operand;
  logic [3:0]                func;
  logic                      logic_mode;
  logic                      carry_in;

  modport source (output valid, output a_operand, output b_operand, output func,
                  output logic_mode, output carry_in, input ready);
  modport sink (input valid, input a_operand, input b_operand, input func,
                input logic_mode, input carry_in, output ready);
endinterface

[rtl/calu_out_if.sv]
// Output channel interface carrying one result item.
interface calu_out_if;
  logic                      valid;
  logic                      ready;
  logic [calu_pkg::WIDTH-1:0] result;
  logic                      carry_out;
  logic                      all_ones;

  modport source (output valid, output result, output carry_out, output all_ones,
                  input ready);
  modport sink (input valid, input result, input carry_out, input all_ones,
                output ready);
endinterface

[rtl/calu_slice.sv]
// Four-bit function-select slice producing result bits and group propagate and generate.
module calu_slice (
  input  logic [calu_pkg::SLICE_W-1:0] a,
  input  logic [calu_pkg::SLICE_W-1:0] b,
  input  logic [3:0]                   func,
  input  logic                         logic_mode,
  input  logic                         cin,
  output logic [calu_pkg::SLICE_W-1:0] f,
  output calu_pkg::grp_t               grp
);

  logic [calu_pkg::SLICE_W-1:0] p;
  logic [calu_pkg::SLICE_W-1:0] g;
  logic [calu_pkg::SLICE_W:0]   c;
  logic [calu_pkg::SLICE_W-1:0] sum;

  always_comb begin
    p = a | (b & {calu_pkg::SLICE_W{func[0]}}) | (~b & {calu_pkg::SLICE_W{func[1]}});
    g = (a & b & {calu_pkg::SLICE_W{func[3]}}) | (a & ~b & {calu_pkg::SLICE_W{func[2]}});
    c[0] = cin;
    grp.prop = 1'b1;
    grp.gen = 1'b0;
    for (int j = 0; j < calu_pkg::SLICE_W; j++) begin
      sum[j] = p[j] ^ g[j] ^ c[j];
      c[j+1] = g[j] | (p[j] & c[j]);
      grp.gen = g[j] | (p[j] & grp.gen);
      grp.prop = grp.prop & p[j];
    end
    f = logic_mode ? ~(p ^ g) : sum;
  end

endmodule

[rtl/calu_cla.sv]
// Group carry lookahead unit forming the carry into each slice and the final carry.
module calu_cla (
  input  calu_pkg::grp_t [calu_pkg::NUM_SLICES-1:0] grp,
  input  logic                                      cin,
  output logic [calu_pkg::NUM_SLICES-1:0]           slice_cin,
  output logic                                      cout
);

  logic [calu_pkg::NUM_SLICES:0] c;

  always_comb begin
    c[0] = cin;
    for (int k = 0; k < calu_pkg::NUM_SLICES; k++) begin
      c[k+1] = grp[k].gen | (grp[k].prop & c[k]);
    end
    slice_cin = c[calu_pkg::NUM_SLICES-1:0];
    cout = c[calu_pkg::NUM_SLICES];
  end

endmodule

[rtl/cascaded_alu_with_carry_lookahead.sv]
// Top level of the cascaded 16-bit ALU with slice-level group carry lookahead.
// An accepted item waits in the input register; its result is held in the result register for res.
// Throughput is one item per cycle unless the receiver stalls, set by the single input-to-result pass.
// The result register takes a new item in the same cycle the previous result is taken.
// Synchronous active-high reset clears both valid flags; payload registers are not reset.
module cascaded_alu_with_carry_lookahead (
  input  logic       clk,
  input  logic       rst,
  calu_in_if.sink    op,
  calu_out_if.source res
);

  calu_pkg::in_item_t  in_reg;
  logic                in_valid;
  logic                in_ready;
  calu_pkg::out_item_t out_reg;
  logic                out_valid;
  logic                out_ready;
  calu_pkg::out_item_t out_next;

  calu_pkg::grp_t [calu_pkg::NUM_SLICES-1:0] grp;
  logic [calu_pkg::NUM_SLICES-1:0]           slice_cin;
  logic [calu_pkg::WIDTH-1:0]                f;
  logic                                      cout;

  assign out_ready = !out_valid || res.ready;
  assign in_ready  = !in_valid || out_ready;
  assign op.ready  = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= op.valid;
    end
    if (in_ready && op.valid) begin
      in_reg.a_operand  <= op.a_operand;
      in_reg.b_operand  <= op.b_operand;
      in_reg.func       <= op.func;
      in_reg.logic_mode <= op.logic_mode;
      in_reg.carry_in   <= op.carry_in;
    end
  end

  for (genvar s = 0; s < calu_pkg::NUM_SLICES; s++) begin : g_slice
    calu_slice u_slice (
      .a          (in_reg.a_operand[s*calu_pkg::SLICE_W +: calu_pkg::SLICE_W]),
      .b          (in_reg.b_operand[s*calu_pkg::SLICE_W +: calu_pkg::SLICE_W]),
      .func       (in_reg.func),
      .logic_mode (in_reg.logic_mode),
      .cin        (slice_cin[s]),
      .f          (f[s*calu_pkg::SLICE_W +: calu_pkg::SLICE_W]),
      .grp        (grp[s])
    );
  end

  calu_cla u_cla (
    .grp       (grp),
    .cin       (in_reg.carry_in),
    .slice_cin (slice_cin),
    .cout      (cout)
  );

  always_comb begin
    out_next.result    = f;
    out_next.carry_out = cout;
    out_next.all_ones  = &f;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= in_valid;
    end
    if (out_ready && in_valid) begin
      out_reg <= out_next;
    end
  end

  assign res.valid     = out_valid;
  assign res.result    = out_reg.result;
  assign res.carry_out = out_reg.carry_out;
  assign res.all_ones  = out_reg.all_ones;

endmodule

[tb/sv/calu_result_checker.sv]
// Checker that predicts each cascaded ALU result and compares it with the output channel.
`timescale 1ns / 100ps

module calu_result_checker (
  input  logic clk,
  input  logic rst,
  calu_in_if   op_mon,
  calu_out_if  res_mon,
  output int   fail_count,
  output int   pending_count
);

  calu_pkg::out_item_t pending_alu_results[$];
  int mismatch_total = 0;

  assign fail_count = mismatch_total;

  function automatic calu_pkg::out_item_t compute_alu_op(input calu_pkg::in_item_t op_item);
    logic [calu_pkg::WIDTH-1:0] a;
    logic [calu_pkg::WIDTH-1:0] b;
    logic [calu_pkg::WIDTH-1:0] prop;
    logic [calu_pkg::WIDTH-1:0] gen;
    logic [calu_pkg::WIDTH-1:0] sum;
    logic [calu_pkg::WIDTH-1:0] f;
    logic                       carry;
    calu_pkg::out_item_t        r;
    a = op_item.a_operand;
    b = op_item.b_operand;
    prop = a | (b & {calu_pkg::WIDTH{op_item.func[0]}})
             | (~b & {calu_pkg::WIDTH{op_item.func[1]}});
    gen = (a & b & {calu_pkg::WIDTH{op_item.func[3]}})
            | (a & ~b & {calu_pkg::WIDTH{op_item.func[2]}});
    carry = op_item.carry_in;
    for (int i = 0; i < calu_pkg::WIDTH; i++) begin
      sum[i] = prop[i] ^ gen[i] ^ carry;
      carry = gen[i] | (prop[i] & carry);
    end
    f = op_item.logic_mode ? ~(prop ^ gen) : sum;
    r.result = f;
    r.carry_out = carry;
    r.all_ones = &f;
    return r;
  endfunction

  always @(posedge clk) begin
    calu_pkg::in_item_t  seen_op;
    calu_pkg::out_item_t want;
    if (rst) begin
      pending_alu_results.delete();
    end else begin
      if (op_mon.valid && op_mon.ready) begin
        seen_op = {op_mon.a_operand, op_mon.b_operand, op_mon.func,
                   op_mon.logic_mode, op_mon.carry_in};
        pending_alu_results.push_back(compute_alu_op(seen_op));
      end
      if (res_mon.valid && res_mon.ready) begin
        if (pending_alu_results.size() == 0) begin
          $error("unexpected result item: result %h carry_out %b all_ones %b",
                 res_mon.result, res_mon.carry_out, res_mon.all_ones);
          mismatch_total++;
        end else begin
          want = pending_alu_results.pop_front();
          if (res_mon.result !== want.result) begin
            $error("result: expected %h, actual %h", want.result, res_mon.result);
            mismatch_total++;
          end
          if (res_mon.carry_out !== want.carry_out) begin
            $error("carry_out: expected %b, actual %b", want.carry_out, res_mon.carry_out);
            mismatch_total++;
          end
          if (res_mon.all_ones !== want.all_ones) begin
            $error("all_ones: expected %b, actual %b", want.all_ones, res_mon.all_ones);
            mismatch_total++;
          end
        end
      end
    end
    pending_count <= pending_alu_results.size();
  end

endmodule

[tb/sv/testbench.sv]
// Top of the cascaded ALU testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module testbench;

  localparam int RANDOM_OPS     = 1200;
  localparam int LONG_HOLD      = 80;
  localparam int HOLD_AT_OP     = 300;
  localparam int QUIET_FIRST    = 600;
  localparam int QUIET_LAST     = 750;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_count;
  int   idle_cycles;
  bit   quiet_stretch;
  bit   hold_request;

  calu_in_if  op_ch ();
  calu_out_if res_ch ();

  cascaded_alu_with_carry_lookahead DUT (
    .clk (clk),
    .rst (rst),
    .op  (op_ch),
    .res (res_ch)
  );

  calu_result_checker result_check (
    .clk           (clk),
    .rst           (rst),
    .op_mon        (op_ch),
    .res_mon       (res_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_stretch || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [calu_pkg::WIDTH-1:0] pick_operand();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return {1'b1, {(calu_pkg::WIDTH-1){1'b0}}};
      default: return r[calu_pkg::WIDTH-1:0];
    endcase
  endfunction

  // Operand pairs cycle through the extremes while every function runs in both modes.
  function automatic calu_pkg::in_item_t directed_op(input int k);
    calu_pkg::in_item_t it;
    case (k % 8)
      0: begin it.a_operand = 16'h0000; it.b_operand = 16'h0000; end
      1: begin it.a_operand = 16'hFFFF; it.b_operand = 16'hFFFF; end
      2: begin it.a_operand = 16'hFFFF; it.b_operand = 16'h0001; end
      3: begin it.a_operand = 16'hAAAA; it.b_operand = 16'h5555; end
      4: begin it.a_operand = 16'h5555; it.b_operand = 16'h5555; end
      5: begin it.a_operand = 16'h8000; it.b_operand = 16'h8000; end
      6: begin it.a_operand = 16'h1234; it.b_operand = 16'h1234; end
      default: begin it.a_operand = 16'h0000; it.b_operand = 16'hFFFF; end
    endcase
    it.func = k[3:0];
    it.logic_mode = k[4];
    it.carry_in = k[0] ^ k[4];
    return it;
  endfunction

  function automatic calu_pkg::in_item_t random_op();
    calu_pkg::in_item_t it;
    it.a_operand = pick_operand();
    it.b_operand = ($urandom_range(0, 4) == 0) ? it.a_operand : pick_operand();
    it.func = 4'($urandom_range(0, 15));
    it.logic_mode = 1'($urandom_range(0, 1));
    it.carry_in = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic send_op(input calu_pkg::in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      op_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op_ch.valid <= 1'b1;
    op_ch.a_operand <= it.a_operand;
    op_ch.b_operand <= it.b_operand;
    op_ch.func <= it.func;
    op_ch.logic_mode <= it.logic_mode;
    op_ch.carry_in <= it.carry_in;
    do @(posedge clk); while (!op_ch.ready);
  endtask

  initial begin : stimulus
    quiet_stretch = 1'b0;
    hold_request = 1'b0;
    rst <= 1'b1;
    op_ch.valid <= 1'b0;
    op_ch.a_operand <= '0;
    op_ch.b_operand <= '0;
    op_ch.func <= '0;
    op_ch.logic_mode <= 1'b0;
    op_ch.carry_in <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int k = 0; k < 32; k++) begin
      send_op(directed_op(k));
    end
    for (int n = 0; n < RANDOM_OPS; n++) begin
      quiet_stretch = (n >= QUIET_FIRST) && (n < QUIET_LAST);
      if (n == HOLD_AT_OP) begin
        hold_request = 1'b1;
      end
      send_op(random_op());
    end
    quiet_stretch = 1'b0;
    op_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : receiver
    int gap;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      gap = pick_gap();
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
